@@ src/prdp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package prdp_pkg;

  // Field widths
  localparam int WORD_W   = 64;
  localparam int CHUNK_W  = 56;
  localparam int MOD_W    = 57;
  localparam int RC_W     = 13;
  localparam int IDX_W    = 12;
  localparam int CFG_IDX_W = 1;

  // Store depth default
  localparam int MAX_CHUNKS_DEF = 4096;

  // Chunk grouping
  localparam int WORDS_PER_GROUP  = 7;
  localparam int CHUNKS_PER_GROUP = 8;

  // Bit-serial step counts
  localparam int CNT_W     = 7;
  localparam int RED_STEPS = MOD_W;
  localparam int MUL_STEPS = WORD_W;

  // Reset values of the registers
  localparam logic [RC_W-1:0]  ROW_CHUNKS_RST = 13'd8;
  localparam logic [MOD_W-1:0] MODULUS_RST    = 57'h1FF_FFFF_FFFF_FFF3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_CHUNKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 1'b1;

  // Input actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_PREP,
    S_RACC,
    S_RCHK,
    S_MUL,
    S_ADD,
    S_NEXT,
    S_EMIT
  } prdp_state_t;

endpackage

`default_nettype wire

@@ src/packed_row_dot_product_mod_prime.sv @@
// Packed-row dot product modulo a prime.
// Input channel (in_valid/in_ready): a transaction with in_action = 0 writes
// in_coef_value into the coefficient store at in_coef_index; with in_action = 1
// it presents the next 64-bit little-endian word of row data. Every 7 words
// unpack into 8 chunks of 56 bits; each chunk is multiplied by the coefficient
// of its column and added into the row sum modulo the modulus register.
// Output channel (out_valid/out_ready): one transaction with the row sum after
// the word that completes a row. Configuration channel (cfg_valid/cfg_ready,
// always ready): index 0 sets row_chunks, index 1 sets the modulus.
// A load is taken in the idle state. Each chunk runs the bit-serial multiply
// unit that walks the 64 coefficient bits; the row sum is first reduced when
// it is not below the modulus (only after a modulus change), and the chunk when
// it is not below the modulus (only for moduli of 56 bits or less). No word is
// taken until every chunk of the previous word is added. After the last chunk
// of a row, the row sum goes through S_NEXT and S_EMIT to the output register.
// Reset clears the row sum, the unpacking state and the registers to their
// defaults; the coefficient store is not cleared and must be written first.
// A stalled receiver holds the result in the output register; the block keeps
// taking words and waits only when the next row result is due.
`timescale 1ns / 1ps
`default_nettype none

module packed_row_dot_product_mod_prime
  import prdp_pkg::*;
#(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_action,
  input  wire logic [IDX_W-1:0]      in_coef_index,
  input  wire logic [WORD_W-1:0]     in_coef_value,
  input  wire logic [WORD_W-1:0]     in_data_word,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [MOD_W-1:0]           out_dot_product,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [MOD_W-1:0]      cfg_data
);

  localparam int AW      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int PW      = $clog2(MAX_CHUNKS + 1);
  localparam int LW      = (PW > RC_W) ? PW : RC_W;
  localparam int CAP_RAW = (MAX_CHUNKS / CHUNKS_PER_GROUP) * CHUNKS_PER_GROUP;
  localparam int CAP     = (CAP_RAW < CHUNKS_PER_GROUP) ? CHUNKS_PER_GROUP : CAP_RAW;

  prdp_state_t state_r, state_nxt;

  // Configuration registers
  logic [RC_W-1:0]  row_chunks_r;
  logic [MOD_W-1:0] modulus_r;

  // Row state
  logic [CHUNK_W-1:0] leftover_r, leftover_nxt;
  logic [2:0]         phase_r, phase_nxt;
  logic [PW-1:0]      pos_r;
  logic [MOD_W-1:0]   acc_r;
  logic               two_r;
  logic               grp_end_r;

  // Datapath payload
  logic [CHUNK_W-1:0] chunk_r;
  logic [CHUNK_W-1:0] chunk2_r;
  logic [WORD_W-1:0]  sh_r;
  logic [MOD_W-1:0]   rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [WORD_W-1:0]  coef_q_r;

  // Output register
  logic               out_valid_r;
  logic [MOD_W-1:0]   out_dot_r;

  // Coefficient store
  logic [WORD_W-1:0] store_mem [MAX_CHUNKS];

  // Control outputs of the state machine
  logic in_ready_c;
  logic rd_en_c;
  logic emit_fire_c;

  logic in_fire;
  logic load_fire;
  logic data_fire;
  logic [31:0] idx_ext;

  // Unpacking of the incoming word
  logic [2:0]          k_c;
  logic [5:0]          shl_c;
  logic [5:0]          shr_c;
  logic [WORD_W-1:0]   chunk_full_c;
  logic [WORD_W-1:0]   left_full_c;
  logic [CHUNK_W-1:0]  chunk0_c;

  // Row length
  logic [RC_W-1:0] rc_floor_c;
  logic [LW-1:0]   len_c;
  logic            row_done_c;

  // Shared serial step
  logic              red_mode_c;
  logic [MOD_W:0]    dbl_c;
  logic [MOD_W-1:0]  d1_c;
  logic [MOD_W:0]    sum_c;
  logic [MOD_W-1:0]  d2_c;
  logic [MOD_W-1:0]  step_c;
  logic              last_step_c;
  logic [MOD_W:0]    acc_sum_c;
  logic [MOD_W-1:0]  acc_add_c;
  logic              mod_zero_c;
  logic              acc_big_c;
  logic              chunk_big_c;

  assign in_fire   = in_valid & in_ready_c;
  assign load_fire = in_fire & (in_action == ACT_LOAD);
  assign data_fire = in_fire & (in_action == ACT_DATA);
  assign idx_ext   = 32'(in_coef_index);

  // Unpack: shift the new word above the leftover bits of the previous one
  always_comb begin
    k_c          = (phase_r >= 3'(WORDS_PER_GROUP)) ? 3'd0 : phase_r;
    shl_c        = {k_c, 3'b000};
    shr_c        = 6'(CHUNK_W) - shl_c;
    chunk_full_c = ((k_c == 3'd0) ? '0 : WORD_W'(leftover_r)) | (in_data_word << shl_c);
    left_full_c  = in_data_word >> shr_c;
    chunk0_c     = chunk_full_c[CHUNK_W-1:0];
    if (k_c == 3'(WORDS_PER_GROUP - 1)) begin
      leftover_nxt = '0;
      phase_nxt    = 3'd0;
    end else begin
      leftover_nxt = left_full_c[CHUNK_W-1:0];
      phase_nxt    = k_c + 3'd1;
    end
  end

  // Effective row length: multiple of eight, clamped to the store
  always_comb begin
    rc_floor_c = {row_chunks_r[RC_W-1:3], 3'b000};
    if (rc_floor_c < RC_W'(CHUNKS_PER_GROUP)) begin
      len_c = LW'(CHUNKS_PER_GROUP);
    end else if (LW'(rc_floor_c) > LW'(CAP)) begin
      len_c = LW'(CAP);
    end else begin
      len_c = LW'(rc_floor_c);
    end
    row_done_c = (LW'(pos_r) >= len_c);
  end

  // Serial step: reduce mode shifts in one bit, multiply mode doubles and adds
  always_comb begin
    red_mode_c  = (state_r != S_MUL);
    dbl_c       = {rem_r, red_mode_c & sh_r[WORD_W-1]};
    d1_c        = (dbl_c >= {1'b0, modulus_r}) ? MOD_W'(dbl_c - {1'b0, modulus_r})
                                               : dbl_c[MOD_W-1:0];
    sum_c       = {1'b0, d1_c} + (sh_r[WORD_W-1] ? (MOD_W + 1)'(chunk_r) : '0);
    d2_c        = (sum_c >= {1'b0, modulus_r}) ? MOD_W'(sum_c - {1'b0, modulus_r})
                                               : sum_c[MOD_W-1:0];
    step_c      = red_mode_c ? d1_c : d2_c;
    last_step_c = (cnt_r == CNT_W'(1));
    acc_sum_c   = {1'b0, acc_r} + {1'b0, rem_r};
    acc_add_c   = (acc_sum_c >= {1'b0, modulus_r}) ? MOD_W'(acc_sum_c - {1'b0, modulus_r})
                                                   : acc_sum_c[MOD_W-1:0];
    mod_zero_c  = (modulus_r == '0);
    acc_big_c   = (acc_r >= modulus_r);
    chunk_big_c = (MOD_W'(chunk_r) >= modulus_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (data_fire) state_nxt = S_FETCH;
      end
      S_FETCH: state_nxt = S_PREP;
      S_PREP: begin
        if (mod_zero_c)       state_nxt = S_NEXT;
        else if (acc_big_c)   state_nxt = S_RACC;
        else if (chunk_big_c) state_nxt = S_RCHK;
        else                  state_nxt = S_MUL;
      end
      S_RACC: begin
        if (last_step_c) state_nxt = S_PREP;
      end
      S_RCHK: begin
        if (last_step_c) state_nxt = S_MUL;
      end
      S_MUL: begin
        if (last_step_c) state_nxt = S_ADD;
      end
      S_ADD: state_nxt = S_NEXT;
      S_NEXT: begin
        if (two_r)                        state_nxt = S_FETCH;
        else if (grp_end_r && row_done_c) state_nxt = S_EMIT;
        else                              state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State machine outputs
  always_comb begin
    in_ready_c  = 1'b0;
    rd_en_c     = 1'b0;
    emit_fire_c = 1'b0;
    case (state_r)
      S_IDLE:  in_ready_c  = 1'b1;
      S_FETCH: rd_en_c     = 1'b1;
      S_EMIT:  emit_fire_c = !out_valid_r || out_ready;
      default: begin
        in_ready_c = 1'b0;
      end
    endcase
  end

  // Coefficient store: write on load, registered read at the chunk column
  always_ff @(posedge clk) begin
    if (load_fire && (idx_ext < 32'(MAX_CHUNKS))) begin
      store_mem[idx_ext[AW-1:0]] <= in_coef_value;
    end
    if (rd_en_c) begin
      coef_q_r <= store_mem[pos_r[AW-1:0]];
    end
  end

  // Control and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_chunks_r <= ROW_CHUNKS_RST;
      modulus_r    <= MODULUS_RST;
      leftover_r   <= '0;
      phase_r      <= '0;
      pos_r        <= '0;
      acc_r        <= '0;
      two_r        <= 1'b0;
      grp_end_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Take register writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ROW_CHUNKS: row_chunks_r <= cfg_data[RC_W-1:0];
          CFG_MODULUS:    modulus_r    <= cfg_data;
          default:        modulus_r    <= modulus_r;
        endcase
      end

      // Advance unpacking on a data word
      if (data_fire) begin
        leftover_r <= leftover_nxt;
        phase_r    <= phase_nxt;
        two_r      <= (k_c == 3'(WORDS_PER_GROUP - 1));
        grp_end_r  <= (k_c == 3'(WORDS_PER_GROUP - 1));
      end

      case (state_r)
        S_FETCH: pos_r <= pos_r + PW'(1);
        S_PREP: begin
          if (mod_zero_c) acc_r <= '0;
        end
        S_RACC: begin
          if (last_step_c) acc_r <= step_c;
        end
        S_ADD:  acc_r <= acc_add_c;
        S_NEXT: begin
          if (two_r) two_r <= 1'b0;
        end
        S_EMIT: begin
          if (emit_fire_c) begin
            acc_r <= '0;
            pos_r <= '0;
          end
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase

      // Hold the result until the receiver takes it
      if (emit_fire_c) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    if (data_fire) begin
      chunk_r  <= chunk0_c;
      chunk2_r <= left_full_c[CHUNK_W-1:0];
    end
    case (state_r)
      S_PREP: begin
        rem_r <= '0;
        if (acc_big_c) begin
          sh_r  <= {acc_r, (WORD_W - MOD_W)'(0)};
          cnt_r <= CNT_W'(RED_STEPS);
        end else if (chunk_big_c) begin
          sh_r  <= {1'b0, chunk_r, (WORD_W - MOD_W)'(0)};
          cnt_r <= CNT_W'(RED_STEPS);
        end else begin
          sh_r  <= coef_q_r;
          cnt_r <= CNT_W'(MUL_STEPS);
        end
      end
      S_RACC: begin
        rem_r <= step_c;
        sh_r  <= sh_r << 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      S_RCHK: begin
        if (last_step_c) begin
          chunk_r <= step_c[CHUNK_W-1:0];
          rem_r   <= '0;
          sh_r    <= coef_q_r;
          cnt_r   <= CNT_W'(MUL_STEPS);
        end else begin
          rem_r <= step_c;
          sh_r  <= sh_r << 1;
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
      S_MUL: begin
        rem_r <= step_c;
        sh_r  <= sh_r << 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      S_NEXT: begin
        if (two_r) chunk_r <= chunk2_r;
      end
      S_EMIT: begin
        if (emit_fire_c) out_dot_r <= acc_r;
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign in_ready        = in_ready_c;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_dot_product = out_dot_r;

endmodule

`default_nettype wire
